### hdl/tds_pkg.sv
// Package: constants, payload types and controller/datapath command types for the solver.
package tds_pkg;

    localparam int MaxN     = 64;
    localparam int FracBits = 16;
    localparam int AddrW    = $clog2(MaxN);
    localparam int CntW     = AddrW + 1;
    localparam int QuoW     = 32 + FracBits + 1;

    localparam logic signed [63:0] QMax = 64'sd2147483647;
    localparam logic signed [63:0] QMin = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs;
        logic               last_row;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [5:0]         row_index;
        logic               last_item;
        logic               singular;
    } t_out_beat;

    // Datapath commands
    localparam logic [3:0] CmdNone    = 4'd0;
    localparam logic [3:0] CmdLoad    = 4'd1;
    localparam logic [3:0] CmdMul     = 4'd2;
    localparam logic [3:0] CmdPivot   = 4'd3;
    localparam logic [3:0] CmdDivG    = 4'd4;
    localparam logic [3:0] CmdDivB    = 4'd5;
    localparam logic [3:0] CmdStore   = 4'd6;
    localparam logic [3:0] CmdRdStart = 4'd7;
    localparam logic [3:0] CmdBackMul = 4'd8;
    localparam logic [3:0] CmdBackAdd = 4'd9;
    localparam logic [3:0] CmdClear   = 4'd10;
    localparam logic [3:0] CmdStep    = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic is_last;
        logic row_zero;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > QMax) return 32'sh7fffffff;
        if (v < QMin) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [31:0] p,
                                                   input logic signed [31:0] q);
        logic signed [63:0] m;
        m = 64'(p) * 64'(q);
        return m >>> FracBits;
    endfunction

endpackage

### hdl/tds_ram.sv
// Generic single-port RAM with registered read.
module tds_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/tds_div.sv
// Restoring divider: saturated signed Q quotient, one bit per cycle.
module tds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo,
    output logic               o_zero
);
    localparam int NW = 32 + tds_pkg::FracBits;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0]   r_rem_n, n_rem_n;
    logic [32:0]     r_part, n_part;
    logic [32:0]     r_den, n_den;
    logic [NW-1:0]   r_q, n_q;
    logic            r_neg, n_neg;
    logic            r_num_zero, n_num_zero;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [SW-1:0]   r_cnt, n_cnt;
    logic [33:0]     w_trial;
    logic [NW:0]     w_sq;

    assign o_done = r_done;
    assign w_sq = r_neg ? -{1'b0, r_q} : {1'b0, r_q};

    always_comb begin
        if (r_num_zero) o_quo = 32'sd0;
        else if ($signed(w_sq) > $signed((NW+1)'(tds_pkg::QMax))) o_quo = 32'sh7fffffff;
        else if ($signed(w_sq) < $signed((NW+1)'(tds_pkg::QMin))) o_quo = 32'sh80000000;
        else o_quo = w_sq[31:0];
    end

    always_comb begin
        n_rem_n = r_rem_n; n_part = r_part; n_den = r_den; n_q = r_q;
        n_neg = r_neg; n_num_zero = r_num_zero; n_busy = r_busy; n_done = 1'b0;
        n_cnt = r_cnt;
        w_trial = {r_part, r_rem_n[NW-1]} - {1'b0, r_den};
        if (i_start) begin
            n_rem_n = (i_num[31] ? NW'(-33'(i_num)) : NW'(i_num)) << tds_pkg::FracBits;
            n_den   = i_den[31] ? -33'(i_den) : 33'(i_den);
            n_neg   = i_num[31] ^ i_den[31];
            n_num_zero = (i_num == 32'sd0);
            n_part  = '0;
            n_q     = '0;
            n_cnt   = SW'(NW);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_rem_n = r_rem_n << 1;
            if (!w_trial[33]) begin
                n_part = w_trial[32:0];
                n_q    = {r_q[NW-2:0], 1'b1};
            end else begin
                n_part = {r_part[31:0], r_rem_n[NW-1]};
                n_q    = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == SW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_zero = (r_den == '0);

    always_ff @(posedge i_clk) begin
        r_rem_n <= n_rem_n; r_part <= n_part; r_den <= n_den; r_q <= n_q;
        r_neg <= n_neg; r_num_zero <= n_num_zero; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end
endmodule

### hdl/tds_dp.sv
// Datapath: forward sweep arithmetic, coefficient stores and back substitution.
module tds_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tds_pkg::t_cmd        i_cmd,
    input  tds_pkg::t_in_beat    i_in,
    output tds_pkg::t_status     o_status,
    output tds_pkg::t_out_beat   o_out
);
    localparam int AW = tds_pkg::AddrW;
    localparam int CW = tds_pkg::CntW;

    logic signed [31:0] r_a, r_b, r_c, r_y, r_pg, r_pb, r_piv, r_numb, r_g, r_x;
    logic signed [63:0] r_ma, r_mb;
    logic               r_last, r_sing;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_row, r_rd;
    logic               w_we;
    logic [AW-1:0]      w_addr;
    logic [31:0]        w_gr, w_br;
    logic               w_start;
    logic signed [31:0] w_num, w_q;
    logic               w_done, w_zero;
    logic signed [63:0] w_nb;

    assign w_we   = (i_cmd.op == tds_pkg::CmdStore);
    assign w_addr = w_we ? r_row : r_rd;
    assign w_start = (i_cmd.op == tds_pkg::CmdDivG) || (i_cmd.op == tds_pkg::CmdDivB);
    assign w_num  = (i_cmd.op == tds_pkg::CmdDivG) ? tds_pkg::sat32(-64'(r_c)) : r_numb;
    assign w_nb   = 64'(r_y) - r_mb;

    tds_ram #(.Width(32), .Depth(tds_pkg::MaxN)) u_gram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(r_g), .o_rdata(w_gr));
    tds_ram #(.Width(32), .Depth(tds_pkg::MaxN)) u_bram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_q), .o_rdata(w_br));

    tds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_num(w_num), .i_den(r_piv),
        .o_done(w_done), .o_quo(w_q), .o_zero(w_zero));

    assign o_status.div_done = w_done;
    assign o_status.is_last  = r_last;
    assign o_status.row_zero = (r_rd == '0);

    assign o_out.solution  = r_x;
    assign o_out.row_index = 6'(r_rd);
    assign o_out.last_item = (r_rd == '0);
    assign o_out.singular  = r_sing;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tds_pkg::CmdLoad: begin
                r_row  <= r_cnt[AW-1:0];
                r_last <= i_in.last_row || (r_cnt >= CW'(tds_pkg::MaxN - 1));
                r_a    <= (r_cnt == '0) ? 32'sd0 : i_in.sub_diag;
                r_b    <= i_in.main_diag;
                r_c    <= (i_in.last_row || (r_cnt >= CW'(tds_pkg::MaxN - 1)))
                          ? 32'sd0 : i_in.super_diag;
                r_y    <= i_in.rhs;
            end
            tds_pkg::CmdMul: begin
                r_ma <= tds_pkg::fx_mul(r_a, r_pg);
                r_mb <= tds_pkg::fx_mul(r_a, r_pb);
            end
            tds_pkg::CmdPivot: begin
                r_piv  <= tds_pkg::sat32(r_ma + 64'(r_b));
                r_numb <= tds_pkg::sat32(w_nb);
            end
            tds_pkg::CmdDivB: r_g <= w_q;
            tds_pkg::CmdStore: begin
                r_rd <= r_row;
                r_x  <= 32'sd0;
            end
            tds_pkg::CmdBackMul: r_ma <= tds_pkg::fx_mul(w_gr, r_x);
            tds_pkg::CmdBackAdd: r_x  <= tds_pkg::sat32(r_ma + 64'($signed(w_br)));
            tds_pkg::CmdStep:    r_rd <= r_rd - 1'b1;
            default: ;
        endcase
        if (!i_rst_n) begin
            r_cnt <= '0; r_sing <= 1'b0; r_pg <= '0; r_pb <= '0;
        end else begin
            if (w_done && w_zero) r_sing <= 1'b1;
            if (i_cmd.op == tds_pkg::CmdStore) begin
                r_pg <= r_g;
                r_pb <= w_q;
                if (!r_last) r_cnt <= CW'(r_row) + 1'b1;
            end
            if (i_cmd.op == tds_pkg::CmdClear) begin
                r_cnt <= '0; r_sing <= 1'b0; r_pg <= '0; r_pb <= '0;
            end
        end
    end
endmodule

### hdl/tds_ctrl.sv
// Controller: sequences forward row work, back substitution and result beats.
module tds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tds_pkg::t_status i_status,
    output tds_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] SIdle = 4'd0, SMul = 4'd1, SPiv = 4'd2, SDivG = 4'd3,
        SWaitG = 4'd4, SDivB = 4'd5, SWaitB = 4'd6, SStore = 4'd7, SRd = 4'd8,
        SRdW = 4'd9, SBMul = 4'd10, SBAdd = 4'd11, SOut = 4'd12;

    logic [3:0] r_state, n_state;

    assign o_in_stall  = (r_state != SIdle);
    assign o_out_valid = (r_state == SOut);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = tds_pkg::CmdNone;
        case (r_state)
            SIdle:  if (i_in_valid) begin o_cmd.op = tds_pkg::CmdLoad; n_state = SMul; end
            SMul:   begin o_cmd.op = tds_pkg::CmdMul; n_state = SPiv; end
            SPiv:   begin o_cmd.op = tds_pkg::CmdPivot; n_state = SDivG; end
            SDivG:  begin o_cmd.op = tds_pkg::CmdDivG; n_state = SWaitG; end
            SWaitG: if (i_status.div_done) n_state = SDivB;
            SDivB:  begin o_cmd.op = tds_pkg::CmdDivB; n_state = SWaitB; end
            SWaitB: if (i_status.div_done) begin
                o_cmd.op = tds_pkg::CmdStore;
                n_state  = i_status.is_last ? SRd : SIdle;
            end
            SRd:    n_state = SRdW;
            SRdW:   begin o_cmd.op = tds_pkg::CmdBackMul; n_state = SBAdd; end
            SBAdd:  begin o_cmd.op = tds_pkg::CmdBackAdd; n_state = SOut; end
            SOut:   if (!i_out_stall) begin
                if (i_status.row_zero) begin
                    o_cmd.op = tds_pkg::CmdClear; n_state = SIdle;
                end else begin
                    o_cmd.op = tds_pkg::CmdStep; n_state = SRd;
                end
            end
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= SIdle;
        else          r_state <= n_state;
    end
endmodule

### hdl/tridiagonal_solver.sv
// Top level: Thomas-algorithm tridiagonal solver, Q16.16 fixed point.
//  channel | dir | handshake            | payload
//  in      | in  | i_in_valid/o_in_stall | tds_pkg::t_in_beat (one matrix row)
//  out     | out | o_out_valid/i_out_stall | tds_pkg::t_out_beat (one solution)
// Each row is finished before the next is accepted: two 48-step
// restoring divisions share one divider.
// After the last row, back substitution yields one beat per row, held by output stall, last row first.
// Reset clears counters, flags and previous coefficients; stores need no clearing.
// Input stalls while a row or the back substitution is in progress.
module tridiagonal_solver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tds_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tds_pkg::t_out_beat  o_out_data
);
    tds_pkg::t_cmd    w_cmd;
    tds_pkg::t_status w_status;

    tds_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_status(w_status),
        .o_cmd(w_cmd));

    tds_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_in(i_in_data),
        .o_status(w_status), .o_out(o_out_data));
endmodule

### dv/tridiagonal_solver_check.sv
// Checker: watches both channels, predicts solutions by Thomas algorithm, counts mismatches.
module tridiagonal_solver_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tds_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tds_pkg::t_out_beat i_out_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_solutions,
    output int                 o_systems
);
    logic signed [63:0] gamma_mem [tds_pkg::MaxN];
    logic signed [63:0] beta_mem [tds_pkg::MaxN];
    logic signed [63:0] prev_gamma, prev_beta;
    int                 row_cnt;
    logic               sing_seen;
    tds_pkg::t_out_beat solution_q [$];

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] p,
                                                input logic signed [63:0] q);
        logic signed [63:0] m;
        m = p * q;
        return m >>> tds_pkg::FracBits;
    endfunction

    function automatic logic signed [63:0] qdiv(input logic signed [63:0] num,
                                                input logic signed [63:0] den,
                                                inout logic sing);
        logic signed [63:0] sn;
        if (den == 0) begin
            sing = 1'b1;
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        sn = num <<< tds_pkg::FracBits;
        return clamp32(sn / den);
    endfunction

    task automatic solve_row(input tds_pkg::t_in_beat d);
        logic signed [63:0] a, b, c, y, piv, g, be, x;
        logic               last, sing;
        int                 row;
        tds_pkg::t_out_beat r;
        a = 64'(d.sub_diag);
        b = 64'(d.main_diag);
        c = 64'(d.super_diag);
        y = 64'(d.rhs);
        last = d.last_row;
        row = row_cnt;
        sing = sing_seen;
        if (row >= tds_pkg::MaxN - 1) begin
            row = tds_pkg::MaxN - 1;
            last = 1'b1;
        end
        if (row == 0) a = 0;
        if (last) c = 0;
        piv = clamp32(qmul(a, prev_gamma) + b);
        g = qdiv(clamp32(-c), piv, sing);
        be = qdiv(clamp32(y - qmul(a, prev_beta)), piv, sing);
        gamma_mem[row] = g;
        beta_mem[row] = be;
        prev_gamma = g;
        prev_beta = be;
        sing_seen = sing;
        if (!last) begin
            row_cnt = row + 1;
            return;
        end
        x = 0;
        for (int i = row; i >= 0; i--) begin
            x = clamp32(qmul(gamma_mem[i], x) + beta_mem[i]);
            r.solution = x[31:0];
            r.row_index = 6'(i);
            r.last_item = (i == 0);
            r.singular = sing_seen;
            solution_q.push_back(r);
        end
        prev_gamma = 0;
        prev_beta = 0;
        row_cnt = 0;
        sing_seen = 1'b0;
        o_systems++;
    endtask

    initial begin
        o_errors = 0;
        o_solutions = 0;
        o_systems = 0;
        prev_gamma = 0;
        prev_beta = 0;
        row_cnt = 0;
        sing_seen = 1'b0;
    end

    assign o_pending = solution_q.size();

    always @(posedge i_clk) begin
        tds_pkg::t_out_beat e;
        if (i_rst_n && i_in_valid && !i_in_stall) solve_row(i_in_data);
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_solutions++;
            if (solution_q.size() == 0) begin
                o_errors++;
                $display("%0t: unexpected beat %p", $time, i_out_data);
            end else begin
                e = solution_q.pop_front();
                if (e !== i_out_data) begin
                    o_errors++;
                    $display("%0t: expected %p actual %p", $time, e, i_out_data);
                end
            end
        end
    end
endmodule

### dv/tridiagonal_solver_test.sv
// Testbench top: drives matrix rows into the solver and reports the verdict.
module tridiagonal_solver_test;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    tds_pkg::t_in_beat  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tds_pkg::t_out_beat out_data;
    int                 errors, pending, solutions, systems;
    tds_pkg::t_in_beat  row_q [$];

    always #2 i_clk = ~i_clk;

    tridiagonal_solver u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    tridiagonal_solver_check u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending),
        .o_solutions(solutions), .o_systems(systems)
    );

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom();
            4: return $urandom_range(0, 32'h0001ffff);
            5: return -$urandom_range(0, 32'h0001ffff);
            default: return $urandom_range(0, 32'h00080000) - 32'h00040000;
        endcase
    endfunction

    task automatic add_row(input logic [31:0] a, b, c, y, input logic last);
        tds_pkg::t_in_beat d;
        d.sub_diag = a;
        d.main_diag = b;
        d.super_diag = c;
        d.rhs = y;
        d.last_row = last;
        row_q.push_back(d);
    endtask

    // diagonally dominant system with random content, occasionally raw
    task automatic add_system(input int n);
        logic [31:0] a, b, c;
        for (int i = 0; i < n; i++) begin
            a = $urandom_range(0, 32'h00020000) - 32'h00010000;
            c = $urandom_range(0, 32'h00020000) - 32'h00010000;
            b = $urandom_range(32'h00030000, 32'h00100000);
            if ($urandom_range(0, 1)) b = -b;
            if ($urandom_range(0, 5) == 0) begin
                a = pick_value();
                b = pick_value();
                c = pick_value();
            end
            add_row(a, b, c, pick_value(), i == n - 1);
        end
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 3) == 0) && ($time % 2000 > 600);
    end

    initial begin
        int gap;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: 1x1, zero pivot, extremes, singular chain
        add_row(32'h7fffffff, 32'h00010000, 32'h7fffffff, 32'h00050000, 1'b1);
        add_row(32'h0, 32'h0, 32'h00010000, 32'h00010000, 1'b1);
        add_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        add_row(32'h0, 32'h0, 32'h0, 32'h80000000, 1'b1);
        add_row(32'h80000000, 32'h00000001, 32'h80000000, 32'h7fffffff, 1'b0);
        add_row(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000, 1'b1);
        add_row(32'hffffffff, 32'h0, 32'h7fffffff, 32'hffffffff, 1'b0);
        add_row(32'hffffffff, 32'h7fffffff, 32'h0, 32'h1, 1'b0);
        add_row(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 1'b1);
        add_system(3);
        // full store forces the last row
        add_system(tds_pkg::MaxN + 2);
        while (row_q.size() < 250) add_system($urandom_range(1, 8));
        while (row_q.size() > 0) begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 6)) begin
                if (row_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= row_q.pop_front();
                    @(posedge i_clk);
                    while (in_stall) @(posedge i_clk);
                end
            end
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Ran %0d systems, checked %0d solution beats.", systems, solutions);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Timeout after %0d solution beats", solutions);
        $display("Mismatches found");
        $finish;
    end
endmodule
